### sv/head_pan_tilt_slew_limiter_core_defines.svh
// Assertion macros used by the head pan/tilt slew limiter checker.
`ifndef HEAD_PAN_TILT_SLEW_LIMITER_CORE_DEFINES_SVH
`define HEAD_PAN_TILT_SLEW_LIMITER_CORE_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define HPTSL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hptsl check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define HPTSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hptsl check failed");

`endif

### sv/hptsl_pkg.sv
// Types, codes and reset values shared by the head pan/tilt slew limiter.
package hptsl_pkg;

    localparam int AngleW   = 16;
    localparam int MagW     = 15;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;
    localparam int InDataW  = 80;
    localparam int InUserW  = 3;
    localparam int OutDataW = 32;
    localparam int OutUserW = 2;

    typedef enum logic [2:0] {
        REG_YAW_LIMIT     = 3'd0,
        REG_PITCH_MIN     = 3'd1,
        REG_PITCH_MAX     = 3'd2,
        REG_TIP_THRESHOLD = 3'd3,
        REG_OFFSET_NORMAL = 3'd4,
        REG_OFFSET_ACTION = 3'd5,
        REG_PROTECT_PITCH = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PROT_NONE  = 2'd0,
        PROT_BACK  = 2'd1,
        PROT_FRONT = 2'd2
    } prot_t;

    localparam logic [1:0] FALL_BACK  = 2'd1;
    localparam logic [1:0] FALL_FRONT = 2'd2;

    localparam logic [MagW-1:0]          RST_YAW_LIMIT     = 15'd9000;
    localparam logic signed [AngleW-1:0] RST_PITCH_MIN     = -16'sd3000;
    localparam logic signed [AngleW-1:0] RST_PITCH_MAX     = 16'sd7000;
    localparam logic [MagW-1:0]          RST_TIP_THRESHOLD = 15'd2000;
    localparam logic signed [AngleW-1:0] RST_OFFSET_NORMAL = 16'sd1500;
    localparam logic signed [AngleW-1:0] RST_OFFSET_ACTION = 16'sd1000;
    localparam logic [MagW-1:0]          RST_PROTECT_PITCH = 15'd3000;

    typedef struct packed {
        logic [MagW-1:0]          yaw_limit;
        logic signed [AngleW-1:0] pitch_min;
        logic signed [AngleW-1:0] pitch_max;
        logic [MagW-1:0]          tip_threshold;
        logic signed [AngleW-1:0] offset_normal;
        logic signed [AngleW-1:0] offset_action;
        logic [MagW-1:0]          protect_pitch;
    } cfg_t;

    typedef struct packed {
        logic signed [AngleW-1:0] desired_yaw;
        logic signed [AngleW-1:0] desired_pitch;
        logic [MagW-1:0]          yaw_step;
        logic [MagW-1:0]          pitch_step;
        logic signed [AngleW-1:0] body_tilt;
        logic                     action_gait;
        logic [1:0]               fall_mode;
    } item_in_t;

    typedef struct packed {
        logic signed [AngleW-1:0] head_yaw;
        logic signed [AngleW-1:0] head_pitch;
        prot_t                    protect_state;
    } item_out_t;

endpackage

### sv/hptsl_cfg.sv
// Configuration register file of the head pan/tilt slew limiter.
module hptsl_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              we,
    input  logic [hptsl_pkg::CfgIdxW-1:0]     index,
    input  logic [hptsl_pkg::CfgDataW-1:0]    data,
    output hptsl_pkg::cfg_t                   cfg
);

    hptsl_pkg::cfg_t cfg_reg;
    hptsl_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (we)
        begin
            unique case (hptsl_pkg::cfg_reg_t'(index))
                hptsl_pkg::REG_YAW_LIMIT:     cfg_next.yaw_limit     = data[hptsl_pkg::MagW-1:0];
                hptsl_pkg::REG_PITCH_MIN:     cfg_next.pitch_min     = data;
                hptsl_pkg::REG_PITCH_MAX:     cfg_next.pitch_max     = data;
                hptsl_pkg::REG_TIP_THRESHOLD: cfg_next.tip_threshold = data[hptsl_pkg::MagW-1:0];
                hptsl_pkg::REG_OFFSET_NORMAL: cfg_next.offset_normal = data;
                hptsl_pkg::REG_OFFSET_ACTION: cfg_next.offset_action = data;
                hptsl_pkg::REG_PROTECT_PITCH: cfg_next.protect_pitch = data[hptsl_pkg::MagW-1:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.yaw_limit     <= hptsl_pkg::RST_YAW_LIMIT;
            cfg_reg.pitch_min     <= hptsl_pkg::RST_PITCH_MIN;
            cfg_reg.pitch_max     <= hptsl_pkg::RST_PITCH_MAX;
            cfg_reg.tip_threshold <= hptsl_pkg::RST_TIP_THRESHOLD;
            cfg_reg.offset_normal <= hptsl_pkg::RST_OFFSET_NORMAL;
            cfg_reg.offset_action <= hptsl_pkg::RST_OFFSET_ACTION;
            cfg_reg.protect_pitch <= hptsl_pkg::RST_PROTECT_PITCH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/hptsl_axis.sv
// One-axis slew step: move toward the goal by at most one step, snap when close or when forced.
module hptsl_axis
(
    input  logic signed [hptsl_pkg::AngleW-1:0] cur,
    input  logic signed [hptsl_pkg::AngleW-1:0] goal,
    input  logic [hptsl_pkg::MagW-1:0]          step,
    input  logic                                force_snap,
    output logic signed [hptsl_pkg::AngleW-1:0] nxt
);

    logic signed [17:0] cur_ext;
    logic signed [17:0] goal_ext;
    logic signed [17:0] step_ext;
    logic signed [17:0] diff;
    logic [17:0]        mag;
    logic signed [17:0] moved;
    logic               snap;

    assign cur_ext  = {{2{cur[hptsl_pkg::AngleW-1]}}, cur};
    assign goal_ext = {{2{goal[hptsl_pkg::AngleW-1]}}, goal};
    assign step_ext = {3'b000, step};
    assign diff     = goal_ext - cur_ext;
    assign mag      = diff[17] ? 18'(-diff) : 18'(diff);
    assign snap     = (mag < 18'(step_ext)) || force_snap;
    assign moved    = (goal_ext > cur_ext) ? cur_ext + step_ext : cur_ext - step_ext;
    assign nxt      = snap ? goal : moved[hptsl_pkg::AngleW-1:0];

endmodule

### sv/hptsl_head.sv
// Per-item datapath: clamp the commands, slew both axes, apply head protection.
module hptsl_head
(
    input  hptsl_pkg::cfg_t                     cfg,
    input  hptsl_pkg::item_in_t                 item,
    input  logic signed [hptsl_pkg::AngleW-1:0] cur_yaw,
    input  logic signed [hptsl_pkg::AngleW-1:0] cur_pitch,
    output hptsl_pkg::item_out_t                result
);

    logic signed [17:0]                  yaw_in;
    logic signed [17:0]                  lim_ext;
    logic signed [17:0]                  yaw_clamp;
    logic signed [hptsl_pkg::AngleW-1:0] pitch_clamp;
    logic signed [hptsl_pkg::AngleW-1:0] yaw_goal;
    logic signed [hptsl_pkg::AngleW-1:0] yaw_slew;
    logic signed [hptsl_pkg::AngleW-1:0] pitch_slew;
    logic signed [hptsl_pkg::AngleW-1:0] offset;
    logic signed [17:0]                  dev;
    logic signed [17:0]                  thr_ext;
    logic signed [17:0]                  prot_ext;
    logic signed [17:0]                  prot_neg;
    logic                                back_hit;
    logic                                front_hit;

    assign yaw_in  = {{2{item.desired_yaw[hptsl_pkg::AngleW-1]}}, item.desired_yaw};
    assign lim_ext = {3'b000, cfg.yaw_limit};

    always_comb
    begin
        yaw_clamp = yaw_in;
        if (yaw_clamp > lim_ext)
        begin
            yaw_clamp = lim_ext;
        end
        if (yaw_clamp < -lim_ext)
        begin
            yaw_clamp = -lim_ext;
        end
        pitch_clamp = item.desired_pitch;
        if (pitch_clamp < cfg.pitch_min)
        begin
            pitch_clamp = cfg.pitch_min;
        end
        if (pitch_clamp > cfg.pitch_max)
        begin
            pitch_clamp = cfg.pitch_max;
        end
    end

    assign yaw_goal = yaw_clamp[hptsl_pkg::AngleW-1:0];

    hptsl_axis u_yaw
    (
        .cur        (cur_yaw),
        .goal       (yaw_goal),
        .step       (item.yaw_step),
        .force_snap (1'b0),
        .nxt        (yaw_slew)
    );

    hptsl_axis u_pitch
    (
        .cur        (cur_pitch),
        .goal       (pitch_clamp),
        .step       (item.pitch_step),
        .force_snap (cur_pitch[hptsl_pkg::AngleW-1]),
        .nxt        (pitch_slew)
    );

    assign offset    = item.action_gait ? cfg.offset_action : cfg.offset_normal;
    assign dev       = {{2{item.body_tilt[hptsl_pkg::AngleW-1]}}, item.body_tilt}
                     - {{2{offset[hptsl_pkg::AngleW-1]}}, offset};
    assign thr_ext   = {3'b000, cfg.tip_threshold};
    assign prot_ext  = {3'b000, cfg.protect_pitch};
    assign prot_neg  = -prot_ext;
    assign back_hit  = (dev < -thr_ext) || (item.fall_mode == hptsl_pkg::FALL_BACK);
    assign front_hit = (dev > thr_ext) || (item.fall_mode == hptsl_pkg::FALL_FRONT);

    always_comb
    begin
        result.head_yaw      = yaw_slew;
        result.head_pitch    = pitch_slew;
        result.protect_state = hptsl_pkg::PROT_NONE;
        if (back_hit)
        begin
            result.head_yaw      = '0;
            result.head_pitch    = prot_ext[hptsl_pkg::AngleW-1:0];
            result.protect_state = hptsl_pkg::PROT_BACK;
        end
        else if (front_hit)
        begin
            result.head_yaw      = '0;
            result.head_pitch    = prot_neg[hptsl_pkg::AngleW-1:0];
            result.protect_state = hptsl_pkg::PROT_FRONT;
        end
    end

endmodule

### sv/head_pan_tilt_slew_limiter_core.sv
// Head pan/tilt slew limiter top level: input register, datapath, result register.
// Takes one item per clock while the output side keeps up, and returns one result item
// for each, in order. An item is held in the input register; when the output side is free,
// the datapath updates the stored head yaw and pitch and loads the result register.
// The stored yaw/pitch registers are updated once per item, which sets the rate at one
// item per cycle while the output is not stalled. While a result waits, the input
// register still takes one more item. Configuration writes take effect at the next
// clock edge.
module head_pan_tilt_slew_limiter_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // desired_yaw[15:0], desired_pitch[31:16], yaw_step[46:32], pitch_step[61:47],
    // body_tilt[77:62], zero fill[79:78]
    input  logic [hptsl_pkg::InDataW-1:0]       s_axis_tdata,
    // action_gait[0], fall_mode[2:1]
    input  logic [hptsl_pkg::InUserW-1:0]       s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // head_yaw[15:0], head_pitch[31:16]
    output logic [hptsl_pkg::OutDataW-1:0]      m_axis_tdata,
    // protect_state[1:0]
    output logic [hptsl_pkg::OutUserW-1:0]      m_axis_tuser,
    input  logic                                cfg_we,
    input  logic [hptsl_pkg::CfgIdxW-1:0]       cfg_index,
    input  logic [hptsl_pkg::CfgDataW-1:0]      cfg_data
);

    hptsl_pkg::cfg_t                     cfg;
    hptsl_pkg::item_in_t                 in_item;
    hptsl_pkg::item_in_t                 in_item_reg;
    hptsl_pkg::item_out_t                result;
    hptsl_pkg::item_out_t                out_item_reg;
    logic                                in_valid_reg;
    logic                                in_valid_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic signed [hptsl_pkg::AngleW-1:0] cur_yaw_reg;
    logic signed [hptsl_pkg::AngleW-1:0] cur_pitch_reg;
    logic                                s_accept;
    logic                                fire;

    hptsl_cfg u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    assign in_item.desired_yaw   = s_axis_tdata[15:0];
    assign in_item.desired_pitch = s_axis_tdata[31:16];
    assign in_item.yaw_step      = s_axis_tdata[46:32];
    assign in_item.pitch_step    = s_axis_tdata[61:47];
    assign in_item.body_tilt     = s_axis_tdata[77:62];
    assign in_item.action_gait   = s_axis_tuser[0];
    assign in_item.fall_mode     = s_axis_tuser[2:1];

    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    hptsl_head u_head
    (
        .cfg       (cfg),
        .item      (in_item_reg),
        .cur_yaw   (cur_yaw_reg),
        .cur_pitch (cur_pitch_reg),
        .result    (result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_yaw_reg   <= '0;
            cur_pitch_reg <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                cur_yaw_reg   <= result.head_yaw;
                cur_pitch_reg <= result.head_pitch;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg <= in_item;
        end
        if (fire)
        begin
            out_item_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_item_reg.head_pitch, out_item_reg.head_yaw};
    assign m_axis_tuser  = out_item_reg.protect_state;

endmodule

### sv/hptsl_checker.sv
// Port-level checks for the head pan/tilt slew limiter, bound to the top level.
`include "head_pan_tilt_slew_limiter_core_defines.svh"

module hptsl_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [hptsl_pkg::OutDataW-1:0]      m_axis_tdata,
    input logic [hptsl_pkg::OutUserW-1:0]      m_axis_tuser
);

    `HPTSL_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `HPTSL_ASSERT_SAME(a_prot_code, clk, rst_n, m_axis_tvalid, (m_axis_tuser == hptsl_pkg::PROT_NONE) || (m_axis_tuser == hptsl_pkg::PROT_BACK) || (m_axis_tuser == hptsl_pkg::PROT_FRONT))
    `HPTSL_ASSERT_SAME(a_prot_yaw_zero, clk, rst_n, m_axis_tvalid && (m_axis_tuser != hptsl_pkg::PROT_NONE), m_axis_tdata[15:0] == 16'd0)
    `HPTSL_ASSERT_SAME(a_out_latency, clk, rst_n, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2))

endmodule

bind head_pan_tilt_slew_limiter_core hptsl_checker u_hptsl_checker (.*);

### dv/tb_top.sv
// Self-checking testbench for the head pan/tilt slew limiter core.
module tb_top;
    import hptsl_pkg::*;

    localparam int HOLD_LEN   = 400;
    localparam int QUIET_MAX  = 4000;
    localparam int PHASE_ITEMS = 125;
    localparam int NUM_PHASES = 8;

    class head_target_tracker;
        cfg_t                     cfg;
        logic signed [AngleW-1:0] cur_yaw;
        logic signed [AngleW-1:0] cur_pitch;
        item_out_t                pending_targets[$];
        int                       errors;
        int                       compared;
        int                       overrides;

        function new();
            cfg.yaw_limit     = RST_YAW_LIMIT;
            cfg.pitch_min     = RST_PITCH_MIN;
            cfg.pitch_max     = RST_PITCH_MAX;
            cfg.tip_threshold = RST_TIP_THRESHOLD;
            cfg.offset_normal = RST_OFFSET_NORMAL;
            cfg.offset_action = RST_OFFSET_ACTION;
            cfg.protect_pitch = RST_PROTECT_PITCH;
            cur_yaw   = '0;
            cur_pitch = '0;
            errors    = 0;
            compared  = 0;
            overrides = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CfgDataW-1:0] val);
            case (idx)
                REG_YAW_LIMIT:     cfg.yaw_limit     = val[MagW-1:0];
                REG_PITCH_MIN:     cfg.pitch_min     = val;
                REG_PITCH_MAX:     cfg.pitch_max     = val;
                REG_TIP_THRESHOLD: cfg.tip_threshold = val[MagW-1:0];
                REG_OFFSET_NORMAL: cfg.offset_normal = val;
                REG_OFFSET_ACTION: cfg.offset_action = val;
                REG_PROTECT_PITCH: cfg.protect_pitch = val[MagW-1:0];
                default: ;
            endcase
        endfunction

        function logic signed [AngleW-1:0] slew_axis(logic signed [AngleW-1:0] cur,
                                                     int goal, logic [MagW-1:0] step,
                                                     bit snap);
            int diff;
            int mag;
            int c;
            int s;
            c = int'(cur);
            s = int'(step);
            diff = goal - c;
            mag = (diff < 0) ? -diff : diff;
            if (mag < s || snap)
                return AngleW'(goal);
            return (goal > c) ? AngleW'(c + s) : AngleW'(c - s);
        endfunction

        function void take_command(item_in_t it);
            int        dyaw;
            int        dpitch;
            int        lim;
            int        thr;
            int        off;
            int        dev;
            item_out_t r;
            dyaw   = int'(it.desired_yaw);
            dpitch = int'(it.desired_pitch);
            lim    = int'(cfg.yaw_limit);
            thr    = int'(cfg.tip_threshold);
            if (dyaw > lim)
                dyaw = lim;
            if (dyaw < -lim)
                dyaw = -lim;
            if (dpitch < int'(cfg.pitch_min))
                dpitch = int'(cfg.pitch_min);
            if (dpitch > int'(cfg.pitch_max))
                dpitch = int'(cfg.pitch_max);
            cur_yaw   = slew_axis(cur_yaw, dyaw, it.yaw_step, 1'b0);
            cur_pitch = slew_axis(cur_pitch, dpitch, it.pitch_step, cur_pitch[AngleW-1]);
            if (it.action_gait)
                off = int'(cfg.offset_action);
            else
                off = int'(cfg.offset_normal);
            dev = int'(it.body_tilt) - off;
            r.protect_state = PROT_NONE;
            if (dev < -thr || it.fall_mode == FALL_BACK)
            begin
                cur_yaw   = '0;
                cur_pitch = AngleW'(int'(cfg.protect_pitch));
                r.protect_state = PROT_BACK;
            end
            else if (dev > thr || it.fall_mode == FALL_FRONT)
            begin
                cur_yaw   = '0;
                cur_pitch = AngleW'(-int'(cfg.protect_pitch));
                r.protect_state = PROT_FRONT;
            end
            if (r.protect_state != PROT_NONE)
                overrides++;
            r.head_yaw   = cur_yaw;
            r.head_pitch = cur_pitch;
            pending_targets.push_back(r);
        endfunction

        function void compare_target(item_out_t act);
            item_out_t exp_t;
            if (pending_targets.size() == 0)
            begin
                $error("result item with no pending target: yaw %0d pitch %0d protect %0d",
                       act.head_yaw, act.head_pitch, act.protect_state);
                errors++;
                return;
            end
            exp_t = pending_targets.pop_front();
            compared++;
            if (act.head_yaw !== exp_t.head_yaw)
            begin
                $error("head_yaw mismatch: expected %0d, got %0d",
                       exp_t.head_yaw, act.head_yaw);
                errors++;
            end
            if (act.head_pitch !== exp_t.head_pitch)
            begin
                $error("head_pitch mismatch: expected %0d, got %0d",
                       exp_t.head_pitch, act.head_pitch);
                errors++;
            end
            if (act.protect_state !== exp_t.protect_state)
            begin
                $error("protect_state mismatch: expected %0d, got %0d",
                       exp_t.protect_state, act.protect_state);
                errors++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata = '0;
    logic [InUserW-1:0]  s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OutDataW-1:0] m_axis_tdata;
    logic [OutUserW-1:0] m_axis_tuser;
    logic                cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    head_target_tracker tracker = new();

    int idle_pct = 26;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet = 0;
    int items_sent = 0;

    head_pan_tilt_slew_limiter_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        item_out_t act;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            act.head_yaw      = m_axis_tdata[15:0];
            act.head_pitch    = m_axis_tdata[31:16];
            act.protect_state = prot_t'(m_axis_tuser);
            tracker.compare_target(act);
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_left = HOLD_LEN;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)))
            quiet = 0;
        else
            quiet = quiet + 1;
        if (quiet >= QUIET_MAX)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int srange(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic item_in_t mk(int dy, int dp, int ys, int ps, int tilt, int act, int fall);
        item_in_t it;
        it.desired_yaw   = AngleW'(dy);
        it.desired_pitch = AngleW'(dp);
        it.yaw_step      = MagW'(ys);
        it.pitch_step    = MagW'(ps);
        it.body_tilt     = AngleW'(tilt);
        it.action_gait   = act[0];
        it.fall_mode     = fall[1:0];
        return it;
    endfunction

    function automatic logic [MagW-1:0] rand_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 60)
            return MagW'(srange(0, 500));
        if (r < 90)
            return MagW'(srange(0, 18000));
        return MagW'($urandom_range(0, 32767));
    endfunction

    function automatic logic [AngleW-1:0] rand_angle();
        if ($urandom_range(0, 99) < 85)
            return AngleW'(srange(-18000, 18000));
        return AngleW'($urandom);
    endfunction

    function automatic item_in_t rand_command();
        item_in_t it;
        int       off;
        int       t;
        int       r;
        it.desired_yaw   = rand_angle();
        it.desired_pitch = rand_angle();
        it.yaw_step      = rand_step();
        it.pitch_step    = rand_step();
        it.action_gait   = 1'($urandom_range(0, 1));
        if (it.action_gait)
            off = int'(tracker.cfg.offset_action);
        else
            off = int'(tracker.cfg.offset_normal);
        t = int'(tracker.cfg.tip_threshold);
        r = $urandom_range(0, 99);
        if (r < 70)
            it.body_tilt = AngleW'(off + srange(-t - 50, t + 50));
        else
            it.body_tilt = rand_angle();
        if ($urandom_range(0, 99) < 85)
            it.fall_mode = 2'd0;
        else
            it.fall_mode = 2'($urandom_range(1, 3));
        return it;
    endfunction

    function automatic cfg_t rand_settings();
        cfg_t c;
        int   a;
        int   b;
        int   tmp;
        a = srange(-18000, 18000);
        b = srange(-18000, 18000);
        if ($urandom_range(0, 4) != 0 && a > b)
        begin
            tmp = a;
            a = b;
            b = tmp;
        end
        c.yaw_limit     = MagW'(srange(0, 18000));
        c.pitch_min     = AngleW'(a);
        c.pitch_max     = AngleW'(b);
        c.tip_threshold = $urandom_range(0, 1) ? MagW'(srange(0, 4000)) : MagW'(srange(0, 18000));
        c.offset_normal = ($urandom_range(0, 3) != 0) ? AngleW'(srange(-3000, 3000))
                                                     : AngleW'(srange(-18000, 18000));
        c.offset_action = ($urandom_range(0, 3) != 0) ? AngleW'(srange(-3000, 3000))
                                                     : AngleW'(srange(-18000, 18000));
        c.protect_pitch = MagW'(srange(0, 18000));
        return c;
    endfunction

    task automatic send_item(input item_in_t it);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, it.body_tilt, it.pitch_step, it.yaw_step,
                          it.desired_pitch, it.desired_yaw};
        s_axis_tuser  <= {it.fall_mode, it.action_gait};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        tracker.take_command(it);
        items_sent++;
    endtask

    task automatic drain_targets();
        while (tracker.pending_targets.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input cfg_reg_t idx, input logic [CfgDataW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        tracker.set_reg(idx, val);
    endtask

    task automatic write_settings(input cfg_t c);
        cfg_write(REG_YAW_LIMIT,     {1'b0, c.yaw_limit});
        cfg_write(REG_PITCH_MIN,     c.pitch_min);
        cfg_write(REG_PITCH_MAX,     c.pitch_max);
        cfg_write(REG_TIP_THRESHOLD, {1'b0, c.tip_threshold});
        cfg_write(REG_OFFSET_NORMAL, c.offset_normal);
        cfg_write(REG_OFFSET_ACTION, c.offset_action);
        cfg_write(REG_PROTECT_PITCH, {1'b0, c.protect_pitch});
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        item_in_t directed[$];
        cfg_t     plan[NUM_PHASES];
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: clamps, slew, snaps, protect edges, fall modes, full-width fields
        directed.push_back(mk(0, 0, 0, 0, 1500, 0, 0));
        directed.push_back(mk(18000, 18000, 18000, 18000, 1500, 0, 0));
        directed.push_back(mk(-18000, -18000, 100, 100, 1500, 0, 0));
        directed.push_back(mk(-18000, -18000, 0, 0, 1500, 0, 0));
        directed.push_back(mk(-18000, -18000, 18000, 18000, 1500, 0, 0));
        directed.push_back(mk(5000, 5000, 10, 10, 1500, 0, 0));
        directed.push_back(mk(5000, 5000, 0, 0, 1500, 0, 0));
        directed.push_back(mk(0, 0, 50, 50, 3500, 0, 0));
        directed.push_back(mk(0, 0, 50, 50, 3501, 0, 0));
        directed.push_back(mk(100, 100, 0, 0, 1500, 0, 0));
        directed.push_back(mk(0, 0, 50, 50, -500, 0, 0));
        directed.push_back(mk(0, 0, 50, 50, -501, 0, 0));
        directed.push_back(mk(0, 0, 50, 50, 3001, 1, 0));
        directed.push_back(mk(0, 0, 50, 50, 3001, 0, 0));
        directed.push_back(mk(0, 0, 50, 50, 1500, 0, 1));
        directed.push_back(mk(0, 0, 50, 50, 1500, 0, 2));
        directed.push_back(mk(0, 0, 50, 50, 1500, 0, 3));
        directed.push_back(mk(0, 0, 50, 50, -1000, 0, 2));
        directed.push_back(mk(0, 0, 50, 50, 4000, 0, 1));
        directed.push_back(mk(32767, -32768, 32767, 32767, 32767, 1, 0));
        directed.push_back(mk(-32768, 32767, 32767, 32767, -32768, 0, 3));
        directed.push_back(mk(-32768, -32768, 1, 1, 1500, 1, 0));
        foreach (directed[i])
            send_item(directed[i]);
        s_axis_tvalid <= 1'b0;
        drain_targets();

        plan[0] = '{yaw_limit: 15'd18000, pitch_min: -16'sd18000, pitch_max: 16'sd18000,
                    tip_threshold: 15'd18000, offset_normal: -16'sd18000,
                    offset_action: 16'sd18000, protect_pitch: 15'd18000};
        plan[1] = '{yaw_limit: 15'd0, pitch_min: 16'sd18000, pitch_max: -16'sd18000,
                    tip_threshold: 15'd0, offset_normal: 16'sd18000,
                    offset_action: -16'sd18000, protect_pitch: 15'd0};
        plan[2] = '{yaw_limit: RST_YAW_LIMIT, pitch_min: RST_PITCH_MIN,
                    pitch_max: RST_PITCH_MAX, tip_threshold: RST_TIP_THRESHOLD,
                    offset_normal: RST_OFFSET_NORMAL, offset_action: RST_OFFSET_ACTION,
                    protect_pitch: RST_PROTECT_PITCH};
        for (int p = 3; p < NUM_PHASES; p++)
            plan[p] = rand_settings();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_settings(plan[p]);
            idle_pct <= (p == 4) ? 0 : 26;
            if (p == 3)
                hold_seq <= hold_seq + 1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(rand_command());
            s_axis_tvalid <= 1'b0;
            drain_targets();
        end

        repeat (10) @(posedge clk);
        $display("Sent %0d items under %0d register settings (extremes and inverted window).",
                 items_sent, NUM_PHASES + 1);
        $display("Compared %0d results, %0d with head protect applied.",
                 tracker.compared, tracker.overrides);
        if (tracker.errors == 0 && tracker.pending_targets.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
